// ----- rtl/core/differential_key_guess_counter_unit_assert.svh -----
// Assertion macros shared by the counter unit and its cells.
// Every use samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef DIFFERENTIAL_KEY_GUESS_COUNTER_UNIT_ASSERT_SVH
`define DIFFERENTIAL_KEY_GUESS_COUNTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define DKGC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dkgc assertion failed");

`define DKGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dkgc assertion failed");

`else

`define DKGC_ASSERT_NOW(label, ante, cons)

`define DKGC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- rtl/core/dkgc_pkg.sv -----
`timescale 1ns / 1ps

package dkgc_pkg;

  localparam int COUNT_BITS = 17;
  localparam int OUT_BITS   = 17;
  localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
  localparam int NUM_GUESS  = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [OUT_BITS-1:0]   OUT_MAX   = {OUT_BITS{1'b1}};

  localparam logic [1:0] CFG_NIBBLE_SELECT = 2'd0;
  localparam logic [1:0] CFG_TARGET_DIFF   = 2'd1;

  localparam logic [1:0] NIBBLE_SELECT_RESET = 2'd0;
  localparam logic [3:0] TARGET_DIFF_RESET   = 4'h9;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [15:0] cipher_a;
    logic [15:0] cipher_b;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [3:0]          best_key;
    logic [OUT_BITS-1:0] best_count;
  } out_t;

  // One item as it travels down the row of cells, with the running best guess.
  typedef struct packed {
    logic       valid;
    logic       hit;
    logic [3:0] na;
    logic [3:0] nb;
    logic       last;
    logic [3:0] best_key;
    count_t     best_count;
  } token_t;

  function automatic logic [3:0] inv_sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h2;
      4'h1: y = 4'hD;
      4'h2: y = 4'h4;
      4'h3: y = 4'h1;
      4'h4: y = 4'hE;
      4'h5: y = 4'h8;
      4'h6: y = 4'hA;
      4'h7: y = 4'h3;
      4'h8: y = 4'hC;
      4'h9: y = 4'hB;
      4'hA: y = 4'h9;
      4'hB: y = 4'h7;
      4'hC: y = 4'h5;
      4'hD: y = 4'hF;
      4'hE: y = 4'h0;
      default: y = 4'h6;
    endcase
    return y;
  endfunction

  function automatic logic [OUT_BITS-1:0] clip_count(input count_t c);
    logic [WIDE_BITS-1:0] wide;
    logic [OUT_BITS-1:0]  res;
    wide = WIDE_BITS'(c);
    if (wide > WIDE_BITS'(OUT_MAX)) begin
      res = OUT_MAX;
    end else begin
      res = wide[OUT_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/dkgc_front.sv -----
`timescale 1ns / 1ps

module dkgc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [3:0]      cfg_wdata_i,
  input  dkgc_pkg::in_t   in_data_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  output dkgc_pkg::token_t tok_o,
  output logic [3:0]      target_diff_o
);
  import dkgc_pkg::*;

  logic [1:0]  nibble_select_q, nibble_select_d;
  logic [3:0]  target_diff_q, target_diff_d;
  logic [15:0] diff;
  logic [15:0] sel_mask;
  logic [15:0] a_shift, b_shift;

  always_comb begin
    nibble_select_d = nibble_select_q;
    target_diff_d   = target_diff_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NIBBLE_SELECT: nibble_select_d = cfg_wdata_i[1:0];
        CFG_TARGET_DIFF:   target_diff_d   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nibble_select_q <= NIBBLE_SELECT_RESET;
      target_diff_q   <= TARGET_DIFF_RESET;
    end else begin
      nibble_select_q <= nibble_select_d;
      target_diff_q   <= target_diff_d;
    end
  end

  // A pair counts only if its difference lies entirely, and nonzero, in the selected nibble.
  always_comb begin
    diff     = in_data_i.cipher_a ^ in_data_i.cipher_b;
    sel_mask = 16'h000F << {nibble_select_q, 2'b00};
    a_shift  = in_data_i.cipher_a >> {nibble_select_q, 2'b00};
    b_shift  = in_data_i.cipher_b >> {nibble_select_q, 2'b00};

    tok_o            = '0;
    tok_o.valid      = in_valid_i && in_ready_i;
    tok_o.hit        = (|(diff & sel_mask)) && !(|(diff & ~sel_mask));
    tok_o.na         = a_shift[3:0];
    tok_o.nb         = b_shift[3:0];
    tok_o.last       = in_data_i.last;
    tok_o.best_key   = 4'h0;
    tok_o.best_count = '0;
  end

  assign target_diff_o = target_diff_q;

endmodule

// ----- rtl/core/dkgc_cell.sv -----
`timescale 1ns / 1ps

`include "differential_key_guess_counter_unit_assert.svh"

module dkgc_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [3:0]       cell_idx_i,
  input  logic [3:0]       target_diff_i,
  input  dkgc_pkg::token_t tok_i,
  output dkgc_pkg::token_t tok_o
);
  import dkgc_pkg::*;

  count_t cnt_q, cnt_d;
  count_t cnt_new;
  token_t tok_q, tok_d;
  logic   match;
  logic   bump;

  always_comb begin
    match   = (inv_sbox(tok_i.na ^ cell_idx_i) ^ inv_sbox(tok_i.nb ^ cell_idx_i))
              == target_diff_i;
    bump    = tok_i.valid && tok_i.hit && match && (cnt_q != COUNT_MAX);
    cnt_new = bump ? (cnt_q + COUNT_BITS'(1)) : cnt_q;

    // Strictly greater, so the lower index keeps a tie.
    tok_d = tok_i;
    if (tok_i.valid && tok_i.last && (cnt_new > tok_i.best_count)) begin
      tok_d.best_key   = cell_idx_i;
      tok_d.best_count = cnt_new;
    end

    cnt_d = cnt_q;
    if (advance_i && tok_i.valid) begin
      cnt_d = tok_i.last ? '0 : cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      tok_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (advance_i) begin
        tok_q <= tok_d;
      end
    end
  end

  assign tok_o = tok_q;

  `DKGC_ASSERT_NEXT(a_clear_after_last, advance_i && tok_i.valid && tok_i.last, cnt_q == '0)
  `DKGC_ASSERT_NEXT(a_hold_saturated,
                    (cnt_q == COUNT_MAX) && !(advance_i && tok_i.valid && tok_i.last),
                    cnt_q == COUNT_MAX)
  `DKGC_ASSERT_NEXT(a_hold_on_stall, !advance_i, $stable(cnt_q) && $stable(tok_q))

endmodule

// ----- rtl/core/differential_key_guess_counter_unit.sv -----
`timescale 1ns / 1ps
// A result appears on out_valid_o once its last item has passed through the row and the output register.
// Throughput: one item per cycle; the sixteen guess cells form a row that the item walks
// through, one cell per cycle, and the output register holds one pending result.
// The row stalls only when a result reaches its end while the output register is full.
// Reset (rst_ni low, asynchronous) clears all counters, empties the row and the output,
// and sets nibble_select to 0 and target_diff to 9.

`include "differential_key_guess_counter_unit_assert.svh"

module differential_key_guess_counter_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [3:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dkgc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dkgc_pkg::out_t  out_data_o
);
  import dkgc_pkg::*;

  token_t     tok [NUM_GUESS+1];
  logic [3:0] target_diff;
  logic       advance;
  logic       tail_result;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;

  dkgc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_data_i    (in_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (advance),
    .tok_o        (tok[0]),
    .target_diff_o(target_diff)
  );

  for (genvar i = 0; i < NUM_GUESS; i++) begin : g_cell
    dkgc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .advance_i    (advance),
      .cell_idx_i   (4'(i)),
      .target_diff_i(target_diff),
      .tok_i        (tok[i]),
      .tok_o        (tok[i+1])
    );
  end

  assign tail_result = tok[NUM_GUESS].valid && tok[NUM_GUESS].last;
  assign advance     = !(tail_result && out_valid_q && !out_ready_i);
  assign in_ready_o  = advance;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && tail_result) begin
      out_valid_d      = 1'b1;
      out_d.best_key   = tok[NUM_GUESS].best_key;
      out_d.best_count = clip_count(tok[NUM_GUESS].best_count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DKGC_ASSERT_NOW(a_stall_cause, !in_ready_o, out_valid_q && !out_ready_i && tail_result)
  `DKGC_ASSERT_NEXT(a_result_lands, advance && tail_result, out_valid_o)
  `DKGC_ASSERT_NEXT(a_tail_holds, !advance, $stable(tok[NUM_GUESS]) && out_valid_o)

endmodule
